@@ sv/kmdbl_pkg.sv @@
// ----------------------------------------------------------------------------
// Key matrix debounce package
// Shared payload types, register map, state encoding and constants for the
// key matrix debounce and breathing LED block.
// ----------------------------------------------------------------------------
package kmdbl_pkg;

    localparam int ROW_W   = 14;   // bits of one row field
    localparam int IN_ROWS = 5;    // row fields in a transaction
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = 3;

    // register indexes (byte address = 4 * index)
    localparam logic [IDX_W-1:0] REG_DEBOUNCE_SCANS  = 3'd0;
    localparam logic [IDX_W-1:0] REG_LEVEL_UPPER     = 3'd1;
    localparam logic [IDX_W-1:0] REG_LEVEL_LOWER     = 3'd2;
    localparam logic [IDX_W-1:0] REG_PERIOD_BASE     = 3'd3;
    localparam logic [IDX_W-1:0] REG_PRESS_BOOST     = 3'd4;
    localparam logic [IDX_W-1:0] REG_COOLDOWN_LENGTH = 3'd5;

    // register reset values
    localparam logic [7:0]  RST_DEBOUNCE_SCANS  = 8'd5;
    localparam logic [7:0]  RST_LEVEL_UPPER     = 8'd200;
    localparam logic [7:0]  RST_LEVEL_LOWER     = 8'd5;
    localparam logic [15:0] RST_PERIOD_BASE     = 16'd120;
    localparam logic [7:0]  RST_PRESS_BOOST     = 8'd50;
    localparam logic [7:0]  RST_COOLDOWN_LENGTH = 8'd24;
    localparam logic [15:0] RST_STEP_PERIOD     = 16'd200;

    localparam logic [7:0]  PERIOD_NUM  = 8'd200;  // dividend of the period
    localparam logic [7:0]  BOUNCE_STEP = 8'd4;
    localparam logic [7:0]  LEVEL_MAX   = 8'd255;
    localparam logic [15:0] PERIOD_MAX  = 16'hFFFF;

    typedef struct packed {
        logic [ROW_W-1:0] raw_row0;
        logic [ROW_W-1:0] raw_row1;
        logic [ROW_W-1:0] raw_row2;
        logic [ROW_W-1:0] raw_row3;
        logic [ROW_W-1:0] raw_row4;
    } in_t;

    typedef struct packed {
        logic [ROW_W-1:0] stable_row0;
        logic [ROW_W-1:0] stable_row1;
        logic [ROW_W-1:0] stable_row2;
        logic [ROW_W-1:0] stable_row3;
        logic [ROW_W-1:0] stable_row4;
        logic [7:0]       pwm_level;
        logic             committed;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_BOOST,
        ST_STEP,
        ST_DIV,
        ST_PERIOD,
        ST_DONE
    } state_t;

endpackage

@@ sv/kmdbl_div.sv @@
// ----------------------------------------------------------------------------
// Period divider
// Restoring radix-2 divider: constant dividend over an 8-bit divisor, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module kmdbl_div (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       start,
    input  logic [7:0] divisor,
    output logic       done,
    output logic [7:0] quotient
);

    logic       busy_reg, busy_next;
    logic       done_reg, done_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [7:0] rem_reg, rem_next;
    logic [7:0] quo_reg, quo_next;
    logic [7:0] dvs_reg, dvs_next;

    logic [8:0] shifted;
    logic       ge;

    always_comb begin
        shifted   = {rem_reg, quo_reg[7]};
        ge        = shifted >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = kmdbl_pkg::PERIOD_NUM;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            // shift in one dividend bit, subtract when it fits
            rem_next = ge ? 8'(shifted - {1'b0, dvs_reg}) : shifted[7:0];
            quo_next = {quo_reg[6:0], ge};
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'd7) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ sv/key_matrix_debounce_breathing_led_top.sv @@
// Sequencing: a committing scan adds a boost pass over the rows, and a breathing
//   step waits on the restoring divider before the result is offered.
// Throughput: one scan at a time; s_ready is high only while the sequencer is idle.
// Reset (aresetn low, synchronous): registers to defaults, candidate and debounced
//   matrices cleared, brightness zero, ramp rising, no result pending.
// ----------------------------------------------------------------------------
// Key matrix debounce with breathing LED level
// Debounces a full key matrix scan per transaction, boosts brightness on new
// presses and steps a breathing ramp whose period comes from the period divider.
// ----------------------------------------------------------------------------
module key_matrix_debounce_breathing_led_top #(
    parameter int ROWS = 5,
    parameter int COLS = 14
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  kmdbl_pkg::in_t                s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output kmdbl_pkg::out_t               m_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kmdbl_pkg::ADDR_W-1:0]  paddr,
    input  logic [kmdbl_pkg::DATA_W-1:0]  pwdata,
    output logic [kmdbl_pkg::DATA_W-1:0]  prdata,
    output logic                          pready
);

    localparam int RIDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int IN_N   = (ROWS < kmdbl_pkg::IN_ROWS) ? ROWS : kmdbl_pkg::IN_ROWS;
    localparam int CW     = (COLS < kmdbl_pkg::ROW_W) ? COLS : kmdbl_pkg::ROW_W;

    // configuration
    logic [7:0]  debounce_scans_reg, level_upper_reg, level_lower_reg;
    logic [15:0] period_base_reg;
    logic [7:0]  press_boost_reg, cooldown_length_reg;

    // block state
    kmdbl_pkg::state_t state_reg, state_next;
    logic [COLS-1:0]   scan_reg   [ROWS];
    logic [COLS-1:0]   cand_reg   [ROWS];
    logic [COLS-1:0]   stable_reg [ROWS];
    logic [ROWS-1:0]   gained_reg;
    logic [RIDX_W-1:0] ridx_reg;
    logic [7:0]        debounce_count_reg;
    logic [15:0]       tick_count_reg;
    logic [15:0]       step_period_reg;
    logic [7:0]        brightness_reg;
    logic              rising_reg;
    logic [7:0]        cooldown_left_reg;
    logic [7:0]        duty_out_reg;
    logic              commit_reg;
    logic              tick_zero_reg;
    logic              m_valid_reg;
    kmdbl_pkg::out_t   m_data_reg;

    // combinational
    logic [kmdbl_pkg::ROW_W-1:0] raw_rows [kmdbl_pkg::IN_ROWS];
    logic [COLS-1:0]   scan_in [ROWS];
    logic              changed;
    logic [7:0]        cnt_eff;
    logic              commit;
    logic [ROWS-1:0]   gained;
    logic [16:0]       tick_inc;
    logic [15:0]       tick_next;
    logic [8:0]        boost_sum;
    logic [7:0]        boosted;
    logic [7:0]        b1, b2, b3, cd1, cd3;
    logic              r2, r3, up_hit, low_hit;
    logic [7:0]        div_divisor;
    logic              div_start, div_done;
    logic [7:0]        div_quotient;
    logic [16:0]       period_sum;
    logic              out_load;
    logic              cfg_wr;
    logic [kmdbl_pkg::ROW_W-1:0] out_rows [kmdbl_pkg::IN_ROWS];

    kmdbl_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_scans_reg  <= kmdbl_pkg::RST_DEBOUNCE_SCANS;
            level_upper_reg     <= kmdbl_pkg::RST_LEVEL_UPPER;
            level_lower_reg     <= kmdbl_pkg::RST_LEVEL_LOWER;
            period_base_reg     <= kmdbl_pkg::RST_PERIOD_BASE;
            press_boost_reg     <= kmdbl_pkg::RST_PRESS_BOOST;
            cooldown_length_reg <= kmdbl_pkg::RST_COOLDOWN_LENGTH;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                kmdbl_pkg::REG_DEBOUNCE_SCANS:  debounce_scans_reg  <= pwdata[7:0];
                kmdbl_pkg::REG_LEVEL_UPPER:     level_upper_reg     <= pwdata[7:0];
                kmdbl_pkg::REG_LEVEL_LOWER:     level_lower_reg     <= pwdata[7:0];
                kmdbl_pkg::REG_PERIOD_BASE:     period_base_reg     <= pwdata[15:0];
                kmdbl_pkg::REG_PRESS_BOOST:     press_boost_reg     <= pwdata[7:0];
                kmdbl_pkg::REG_COOLDOWN_LENGTH: cooldown_length_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            kmdbl_pkg::REG_DEBOUNCE_SCANS:  prdata = {24'd0, debounce_scans_reg};
            kmdbl_pkg::REG_LEVEL_UPPER:     prdata = {24'd0, level_upper_reg};
            kmdbl_pkg::REG_LEVEL_LOWER:     prdata = {24'd0, level_lower_reg};
            kmdbl_pkg::REG_PERIOD_BASE:     prdata = {16'd0, period_base_reg};
            kmdbl_pkg::REG_PRESS_BOOST:     prdata = {24'd0, press_boost_reg};
            kmdbl_pkg::REG_COOLDOWN_LENGTH: prdata = {24'd0, cooldown_length_reg};
            default:                        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // input mapping: fields to matrix rows, extra rows and columns read 0
    // ------------------------------------------------------------------
    assign raw_rows[0] = s_data.raw_row0;
    assign raw_rows[1] = s_data.raw_row1;
    assign raw_rows[2] = s_data.raw_row2;
    assign raw_rows[3] = s_data.raw_row3;
    assign raw_rows[4] = s_data.raw_row4;

    always_comb begin
        for (int r = 0; r < ROWS; r++) begin
            scan_in[r] = '0;
        end
        for (int r = 0; r < IN_N; r++) begin
            for (int c = 0; c < CW; c++) begin
                scan_in[r][c] = raw_rows[r][c];
            end
        end
    end

    // ------------------------------------------------------------------
    // scan evaluation (ST_LOAD)
    // ------------------------------------------------------------------
    always_comb begin
        changed = 1'b0;
        for (int r = 0; r < ROWS; r++) begin
            if (scan_reg[r] != cand_reg[r]) begin
                changed = 1'b1;
            end
            gained[r] = |(scan_reg[r] & ~stable_reg[r]);
        end
        cnt_eff = changed ? debounce_scans_reg : debounce_count_reg;
        commit  = (cnt_eff == 8'd1);

        // period never drops below tick + 1 except through a zero period
        tick_inc  = {1'b0, tick_count_reg} + 17'd1;
        tick_next = (step_period_reg == 16'd0 || tick_inc >= {1'b0, step_period_reg})
                    ? 16'd0 : tick_inc[15:0];
    end

    // saturating boost add (ST_BOOST)
    assign boost_sum = {1'b0, brightness_reg} + {1'b0, press_boost_reg};
    assign boosted   = boost_sum[8] ? kmdbl_pkg::LEVEL_MAX : boost_sum[7:0];

    // ------------------------------------------------------------------
    // breathing step (ST_STEP)
    // ------------------------------------------------------------------
    always_comb begin
        cd1 = cooldown_left_reg;
        if (cooldown_left_reg != 8'd0) begin
            cd1 = cooldown_left_reg - 8'd1;
            b1  = brightness_reg;
        end else if (rising_reg) begin
            b1 = (brightness_reg == kmdbl_pkg::LEVEL_MAX) ? brightness_reg
                                                          : brightness_reg + 8'd1;
        end else begin
            b1 = (brightness_reg == 8'd0) ? 8'd0 : brightness_reg - 8'd1;
        end

        // bounce back from the upper limit
        up_hit = b1 > level_upper_reg;
        if (up_hit) begin
            b2 = (b1 >= kmdbl_pkg::BOUNCE_STEP) ? b1 - kmdbl_pkg::BOUNCE_STEP : 8'd0;
        end else begin
            b2 = b1;
        end
        r2 = up_hit ? 1'b0 : rising_reg;

        // clamp at the floor and start the cool-down
        low_hit = (b2 < level_lower_reg) && (cd1 == 8'd0);
        b3  = low_hit ? level_lower_reg : b2;
        r3  = low_hit ? 1'b1 : r2;
        cd3 = low_hit ? cooldown_length_reg : cd1;

        div_divisor = (b3 == 8'd0) ? 8'd1 : b3;
    end

    assign period_sum = {9'd0, div_quotient} + {1'b0, period_base_reg};

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= kmdbl_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            kmdbl_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = kmdbl_pkg::ST_LOAD;
                end
            end
            kmdbl_pkg::ST_LOAD: begin
                if (commit) begin
                    state_next = kmdbl_pkg::ST_BOOST;
                end else if (tick_next == 16'd0) begin
                    state_next = kmdbl_pkg::ST_STEP;
                end else begin
                    state_next = kmdbl_pkg::ST_DONE;
                end
            end
            kmdbl_pkg::ST_BOOST: begin
                if (ridx_reg == RIDX_W'(ROWS - 1)) begin
                    state_next = tick_zero_reg ? kmdbl_pkg::ST_STEP : kmdbl_pkg::ST_DONE;
                end
            end
            kmdbl_pkg::ST_STEP: begin
                div_start  = 1'b1;
                state_next = kmdbl_pkg::ST_DIV;
            end
            kmdbl_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = kmdbl_pkg::ST_PERIOD;
                end
            end
            kmdbl_pkg::ST_PERIOD: begin
                state_next = kmdbl_pkg::ST_DONE;
            end
            kmdbl_pkg::ST_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = kmdbl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = kmdbl_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // datapath state
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < ROWS; r++) begin
                cand_reg[r]   <= '0;
                stable_reg[r] <= '0;
            end
            debounce_count_reg <= kmdbl_pkg::RST_DEBOUNCE_SCANS;
            tick_count_reg     <= '0;
            step_period_reg    <= kmdbl_pkg::RST_STEP_PERIOD;
            brightness_reg     <= '0;
            rising_reg         <= 1'b1;
            cooldown_left_reg  <= '0;
            duty_out_reg       <= '0;
            ridx_reg           <= '0;
            commit_reg         <= 1'b0;
            tick_zero_reg      <= 1'b0;
        end else begin
            case (state_reg)
                kmdbl_pkg::ST_LOAD: begin
                    for (int r = 0; r < ROWS; r++) begin
                        cand_reg[r] <= scan_reg[r];
                        if (commit) begin
                            stable_reg[r] <= scan_reg[r];
                        end
                    end
                    debounce_count_reg <= (cnt_eff != 8'd0) ? cnt_eff - 8'd1 : 8'd0;
                    commit_reg         <= commit;
                    tick_count_reg     <= tick_next;
                    tick_zero_reg      <= (tick_next == 16'd0);
                    ridx_reg           <= '0;
                end
                kmdbl_pkg::ST_BOOST: begin
                    if (gained_reg[ridx_reg]) begin
                        brightness_reg <= boosted;
                    end
                    ridx_reg <= ridx_reg + RIDX_W'(1);
                end
                kmdbl_pkg::ST_STEP: begin
                    brightness_reg    <= b3;
                    rising_reg        <= r3;
                    cooldown_left_reg <= cd3;
                    duty_out_reg      <= b3;
                end
                kmdbl_pkg::ST_PERIOD: begin
                    step_period_reg <= period_sum[16] ? kmdbl_pkg::PERIOD_MAX
                                                      : period_sum[15:0];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            for (int r = 0; r < ROWS; r++) begin
                scan_reg[r] <= scan_in[r];
            end
        end
        if (state_reg == kmdbl_pkg::ST_LOAD) begin
            gained_reg <= gained;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_comb begin
        for (int r = 0; r < kmdbl_pkg::IN_ROWS; r++) begin
            out_rows[r] = '0;
        end
        for (int r = 0; r < IN_N; r++) begin
            for (int c = 0; c < CW; c++) begin
                out_rows[r][c] = stable_reg[r][c];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            m_data_reg  <= '0;
        end else begin
            if (out_load) begin
                m_valid_reg            <= 1'b1;
                m_data_reg.stable_row0 <= out_rows[0];
                m_data_reg.stable_row1 <= out_rows[1];
                m_data_reg.stable_row2 <= out_rows[2];
                m_data_reg.stable_row3 <= out_rows[3];
                m_data_reg.stable_row4 <= out_rows[4];
                m_data_reg.pwm_level   <= duty_out_reg;
                m_data_reg.committed   <= commit_reg;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ sv/kmdbl_chk.sv @@
// ----------------------------------------------------------------------------
// Key matrix debounce port checker
// Watches the top-level ports for handshake and sequencing properties.
// ----------------------------------------------------------------------------
module kmdbl_chk (
    input logic            aclk,
    input logic            aresetn,
    input logic            s_valid,
    input logic            s_ready,
    input logic            m_valid,
    input logic            m_ready,
    input kmdbl_pkg::out_t m_data
);

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or dropped while stalled");

    // one scan in flight: busy right after a transaction is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a scan is in progress");

    // reset empties the output and opens the input
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("reset did not clear the block");

    // debounced rows only move on a committing scan
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.committed |->
            m_data.stable_row0 == $past(m_data.stable_row0) &&
            m_data.stable_row1 == $past(m_data.stable_row1) &&
            m_data.stable_row2 == $past(m_data.stable_row2) &&
            m_data.stable_row3 == $past(m_data.stable_row3) &&
            m_data.stable_row4 == $past(m_data.stable_row4))
        else $error("debounced rows changed without a commit");

endmodule

bind key_matrix_debounce_breathing_led_top kmdbl_chk u_kmdbl_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

@@ dv/kmdbl_scan_checker.sv @@
// ----------------------------------------------------------------------------
// Key matrix debounce scan checker
// Watches the scan, result and register ports of the debounce block, predicts
// the debounced rows, commit flag and breathing LED level of every accepted
// scan, and compares each result transaction field by field in order.
// ----------------------------------------------------------------------------
module kmdbl_scan_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  kmdbl_pkg::in_t                s_data,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  kmdbl_pkg::out_t               m_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [kmdbl_pkg::ADDR_W-1:0]  paddr,
    input  logic [kmdbl_pkg::DATA_W-1:0]  pwdata,
    output int                            mismatches,
    output int                            pending
);

    // register copies
    logic [7:0]  cfg_debounce;
    logic [7:0]  cfg_upper;
    logic [7:0]  cfg_lower;
    logic [15:0] cfg_base;
    logic [7:0]  cfg_boost;
    logic [7:0]  cfg_cooldown;

    // matrix and breathing state
    logic [kmdbl_pkg::ROW_W-1:0] cand_rows [kmdbl_pkg::IN_ROWS];
    logic [kmdbl_pkg::ROW_W-1:0] key_rows [kmdbl_pkg::IN_ROWS];
    logic [7:0]       settle_count;
    logic [15:0]      tick_count;
    logic [15:0]      step_period;
    logic [7:0]       brightness;
    logic             ramp_up;
    logic [7:0]       cooldown_left;
    logic [7:0]       duty;

    kmdbl_pkg::out_t expected_scans [$];
    int   errors = 0;

    function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b);
        return (kmdbl_pkg::LEVEL_MAX - a >= b) ? a + b : kmdbl_pkg::LEVEL_MAX;
    endfunction

    function automatic logic [7:0] sat_sub(input logic [7:0] a, input logic [7:0] b);
        return (a >= b) ? a - b : 8'd0;
    endfunction

    // Advance the model by one scan and produce its result transaction.
    task automatic step_scan(input kmdbl_pkg::in_t scan, output kmdbl_pkg::out_t res);
        logic [kmdbl_pkg::ROW_W-1:0] raw [kmdbl_pkg::IN_ROWS];
        logic             commit;
        int               p;
        raw[0] = scan.raw_row0;
        raw[1] = scan.raw_row1;
        raw[2] = scan.raw_row2;
        raw[3] = scan.raw_row3;
        raw[4] = scan.raw_row4;
        commit = 1'b0;

        for (int r = 0; r < kmdbl_pkg::IN_ROWS; r++) begin
            if (cand_rows[r] != raw[r]) begin
                cand_rows[r] = raw[r];
                settle_count = cfg_debounce;
            end
        end

        if (settle_count != 0) begin
            settle_count = settle_count - 8'd1;
            if (settle_count == 0) begin
                commit = 1'b1;
                for (int r = 0; r < kmdbl_pkg::IN_ROWS; r++) begin
                    // boost once per row that gains a pressed key
                    if ((cand_rows[r] & ~key_rows[r]) != 0)
                        brightness = sat_add(brightness, cfg_boost);
                    key_rows[r] = cand_rows[r];
                end
            end
        end

        if (step_period == 0)
            tick_count = '0;
        else
            tick_count = 16'((int'(tick_count) + 1) % int'(step_period));

        if (tick_count == 0) begin
            if (cooldown_left != 0)
                cooldown_left = cooldown_left - 8'd1;
            else if (ramp_up)
                brightness = sat_add(brightness, 8'd1);
            else
                brightness = sat_sub(brightness, 8'd1);

            if (brightness > cfg_upper) begin
                ramp_up    = 1'b0;
                brightness = sat_sub(brightness, kmdbl_pkg::BOUNCE_STEP);
            end

            if (brightness < cfg_lower && cooldown_left == 0) begin
                ramp_up       = 1'b1;
                cooldown_left = cfg_cooldown;
                brightness    = cfg_lower;
            end

            duty = brightness;
            p = int'(kmdbl_pkg::PERIOD_NUM) / (brightness == 0 ? 1 : int'(brightness))
                + int'(cfg_base);
            step_period = (p > int'(kmdbl_pkg::PERIOD_MAX)) ? kmdbl_pkg::PERIOD_MAX
                                                            : p[15:0];
        end

        res.stable_row0 = key_rows[0];
        res.stable_row1 = key_rows[1];
        res.stable_row2 = key_rows[2];
        res.stable_row3 = key_rows[3];
        res.stable_row4 = key_rows[4];
        res.pwm_level   = duty;
        res.committed   = commit;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin : monitor
        kmdbl_pkg::out_t want;
        if (!aresetn) begin
            cfg_debounce  = kmdbl_pkg::RST_DEBOUNCE_SCANS;
            cfg_upper     = kmdbl_pkg::RST_LEVEL_UPPER;
            cfg_lower     = kmdbl_pkg::RST_LEVEL_LOWER;
            cfg_base      = kmdbl_pkg::RST_PERIOD_BASE;
            cfg_boost     = kmdbl_pkg::RST_PRESS_BOOST;
            cfg_cooldown  = kmdbl_pkg::RST_COOLDOWN_LENGTH;
            for (int r = 0; r < kmdbl_pkg::IN_ROWS; r++) begin
                cand_rows[r] = '0;
                key_rows[r]  = '0;
            end
            settle_count  = kmdbl_pkg::RST_DEBOUNCE_SCANS;
            tick_count    = '0;
            step_period   = kmdbl_pkg::RST_STEP_PERIOD;
            brightness    = '0;
            ramp_up       = 1'b1;
            cooldown_left = '0;
            duty          = '0;
            expected_scans.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[kmdbl_pkg::ADDR_W-1:2])
                    kmdbl_pkg::REG_DEBOUNCE_SCANS:  cfg_debounce = pwdata[7:0];
                    kmdbl_pkg::REG_LEVEL_UPPER:     cfg_upper    = pwdata[7:0];
                    kmdbl_pkg::REG_LEVEL_LOWER:     cfg_lower    = pwdata[7:0];
                    kmdbl_pkg::REG_PERIOD_BASE:     cfg_base     = pwdata[15:0];
                    kmdbl_pkg::REG_PRESS_BOOST:     cfg_boost    = pwdata[7:0];
                    kmdbl_pkg::REG_COOLDOWN_LENGTH: cfg_cooldown = pwdata[7:0];
                    default: ;
                endcase
            end

            // compare before queuing, so a stray result never meets a fresh scan
            if (m_valid && m_ready) begin
                if (expected_scans.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none actual %0h",
                             $time, m_data);
                end else begin
                    want = expected_scans.pop_front();
                    check_field("stable_row0", 32'(want.stable_row0),
                                32'(m_data.stable_row0));
                    check_field("stable_row1", 32'(want.stable_row1),
                                32'(m_data.stable_row1));
                    check_field("stable_row2", 32'(want.stable_row2),
                                32'(m_data.stable_row2));
                    check_field("stable_row3", 32'(want.stable_row3),
                                32'(m_data.stable_row3));
                    check_field("stable_row4", 32'(want.stable_row4),
                                32'(m_data.stable_row4));
                    check_field("pwm_level", 32'(want.pwm_level), 32'(m_data.pwm_level));
                    check_field("committed", 32'(want.committed), 32'(m_data.committed));
                end
            end

            if (s_valid && s_ready) begin
                step_scan(s_data, want);
                expected_scans.push_back(want);
            end
        end
        mismatches <= errors;
        pending    <= expected_scans.size();
    end

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// Key matrix debounce testbench
// Drives directed and randomized key matrix scans through the block under
// several register settings and idle patterns; the scan checker predicts and
// compares every result, and this top gives the verdict.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int NUM_PHASES   = 5;
    localparam int MODE_SPAN    = 25;   // scans per idle pattern

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    kmdbl_pkg::in_t    s_data  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    kmdbl_pkg::out_t   m_data;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [kmdbl_pkg::ADDR_W-1:0] paddr  = '0;
    logic [kmdbl_pkg::DATA_W-1:0] pwdata = '0;
    logic [kmdbl_pkg::DATA_W-1:0] prdata;
    logic              pready;

    int mismatches;
    int pending;
    int cycle_count    = 0;
    int scan_count     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // idle patterns: none, sender only, receiver only, both
    int idle_pct  [4] = '{0, 54, 0, 21};
    int stall_pct [4] = '{0, 0, 54, 21};

    // per phase: debounce, upper, lower, base, boost, cooldown, scans
    int ph_debounce [NUM_PHASES] = '{1,   3,   0,   2,  255};
    int ph_upper    [NUM_PHASES] = '{0,   255, 20,  128, 1};
    int ph_lower    [NUM_PHASES] = '{0,   1,   10,  64,  255};
    int ph_base     [NUM_PHASES] = '{0,   1,   2,   4,   65535};
    int ph_boost    [NUM_PHASES] = '{255, 7,   1,   50,  0};
    int ph_cooldown [NUM_PHASES] = '{0,   3,   255, 24,  255};
    int ph_scans    [NUM_PHASES] = '{70,  70,  40,  70,  260};

    key_matrix_debounce_breathing_led_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    kmdbl_scan_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [kmdbl_pkg::ROW_W-1:0] random_row();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            2:       return kmdbl_pkg::ROW_W'(1) << $urandom_range(kmdbl_pkg::ROW_W - 1);
            default: return kmdbl_pkg::ROW_W'($urandom);
        endcase
    endfunction

    function automatic kmdbl_pkg::in_t random_matrix();
        return {random_row(), random_row(), random_row(), random_row(), random_row()};
    endfunction

    // Present one scan and hold it until the transaction completes.
    task automatic send_scan(input kmdbl_pkg::in_t scan);
        send_idle_pct  = idle_pct[(scan_count / MODE_SPAN) % 4];
        recv_stall_pct = stall_pct[(scan_count / MODE_SPAN) % 4];
        scan_count++;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= scan;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic reg_write(input logic [kmdbl_pkg::IDX_W-1:0] idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // Mostly key patterns held long enough to commit, with bounces and
    // patterns released early mixed in.
    task automatic run_traffic(input int n_scans, input int debounce);
        kmdbl_pkg::in_t target;
        int  hold;
        int  sent;
        sent = 0;
        while (sent < n_scans) begin
            target = random_matrix();
            if ($urandom_range(3) == 0) begin
                repeat ($urandom_range(1, 2)) begin
                    send_scan(random_matrix());
                    sent++;
                end
            end
            if (debounce == 0)
                hold = $urandom_range(1, 4);
            else if ($urandom_range(7) == 0)
                hold = $urandom_range(1, debounce);
            else
                hold = debounce + $urandom_range(0, 3);
            // stop at the phase budget
            if (hold > n_scans - sent)
                hold = n_scans - sent;
            if (hold > 0) begin
                repeat (hold) send_scan(target);
                sent += hold;
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: full press, release, checkerboards, a bounced key
        send_scan('0);
        repeat (5) send_scan({kmdbl_pkg::IN_ROWS{14'h3FFF}});
        repeat (5) send_scan({14'h2AAA, 14'h1555, 14'h2AAA, 14'h1555, 14'h2AAA});
        repeat (5) send_scan({14'h1555, 14'h2AAA, 14'h1555, 14'h2AAA, 14'h1555});
        send_scan({14'h2000, {4{14'h0000}}});
        send_scan({{4{14'h0000}}, 14'h0001});
        repeat (5) send_scan('0);

        for (int p = 0; p < NUM_PHASES; p++) begin
            s_valid <= 1'b0;
            wait_drained();
            reg_write(kmdbl_pkg::REG_DEBOUNCE_SCANS, ph_debounce[p]);
            reg_write(kmdbl_pkg::REG_LEVEL_UPPER, ph_upper[p]);
            reg_write(kmdbl_pkg::REG_LEVEL_LOWER, ph_lower[p]);
            reg_write(kmdbl_pkg::REG_PERIOD_BASE, ph_base[p]);
            reg_write(kmdbl_pkg::REG_PRESS_BOOST, ph_boost[p]);
            reg_write(kmdbl_pkg::REG_COOLDOWN_LENGTH, ph_cooldown[p]);
            run_traffic(ph_scans[p], ph_debounce[p]);
        end

        s_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
